/* design/ctbc_pkg.sv */
// shared types and constants for the cruise tip button controller
package ctbc_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 2'd3;

	// field widths
	localparam int DEADBAND_W = 12;
	localparam int STEP_W     = 12;
	localparam int COOLDOWN_W = 16;
	localparam int CFG_DATA_W = 16;
	localparam int TIME_W     = 32;

	// plan goes stale after this many ms
	localparam logic [TIME_W-1:0] PLAN_TIMEOUT_MS = 32'd500;

	// request kinds
	localparam logic REQ_PLAN = 1'b0;
	localparam logic REQ_TICK = 1'b1;

	typedef struct packed {
		logic                  enable;
		logic [DEADBAND_W-1:0] deadband;
		logic [STEP_W-1:0]     step;
		logic [COOLDOWN_W-1:0] cooldown;
	} cfg_t;

	typedef struct packed {
		logic send;
		logic up;
		logic down;
	} press_t;

endpackage

/* design/ctbc_ctrl.sv */
// controller state and per-word decision logic
module ctbc_ctrl #(
	parameter int COUNTER_BITS = 4,
	parameter int SPEED_BITS   = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  ctbc_pkg::cfg_t                  cfg,
	input  logic                            req_type,
	input  logic [ctbc_pkg::TIME_W-1:0]     now_ms,
	input  logic signed [SPEED_BITS-1:0]    target_speed,
	input  logic                            cruise_on,
	input  logic                            gas_down,
	input  logic                            brake_down,
	input  logic                            button_frame_valid,
	input  logic [COUNTER_BITS-1:0]         button_counter,
	input  logic signed [SPEED_BITS-1:0]    ego_speed,
	output ctbc_pkg::press_t                press
);
	import ctbc_pkg::*;

	localparam int W = SPEED_BITS + 2;

	// architectural state
	logic                          engaged_q;
	logic signed [SPEED_BITS-1:0]  set_speed_q;
	logic signed [SPEED_BITS-1:0]  ceiling_q;
	logic                          hold_up_q;
	logic                          hold_down_q;
	logic                          cool_q;
	logic [TIME_W-1:0]             cool_start_q;
	logic [COUNTER_BITS-1:0]       cnt_press_q;
	logic                          plan_seen_q;
	logic [TIME_W-1:0]             plan_time_q;
	logic signed [SPEED_BITS-1:0]  plan_speed_q;

	// next state
	logic                          engaged_d;
	logic signed [SPEED_BITS-1:0]  set_speed_d;
	logic signed [SPEED_BITS-1:0]  ceiling_d;
	logic                          hold_up_d;
	logic                          hold_down_d;
	logic                          cool_d;
	logic [TIME_W-1:0]             cool_start_d;
	logic [COUNTER_BITS-1:0]       cnt_press_d;
	logic                          plan_seen_d;
	logic [TIME_W-1:0]             plan_time_d;
	logic signed [SPEED_BITS-1:0]  plan_speed_d;

	// engage-adjusted view of the state
	logic                          engage;
	logic signed [SPEED_BITS-1:0]  ego_clamp;
	logic signed [SPEED_BITS-1:0]  set_e;
	logic signed [SPEED_BITS-1:0]  ceil_e;
	logic                          hold_up_e;
	logic                          hold_down_e;
	logic                          cool_e;

	// timing checks
	logic [TIME_W-1:0] plan_age;
	logic [TIME_W-1:0] cool_age;
	logic              fresh;
	logic              cooling;

	// speed error path
	logic signed [SPEED_BITS-1:0] want;
	logic signed [W-1:0]          set_x;
	logic signed [W-1:0]          ceil_x;
	logic signed [W-1:0]          err;
	logic signed [W-1:0]          db_x;
	logic signed [W-1:0]          step_x;
	logic signed [W-1:0]          up_n;
	logic signed [W-1:0]          dn_n;
	logic                         big_err;
	logic                         err_pos;
	logic signed [SPEED_BITS-1:0] up_set;
	logic signed [SPEED_BITS-1:0] dn_set;

	assign engage      = cruise_on && !engaged_q;
	assign ego_clamp   = ego_speed[SPEED_BITS-1] ? '0 : ego_speed;
	assign set_e       = engage ? ego_clamp : set_speed_q;
	assign ceil_e      = engage ? ego_clamp : ceiling_q;
	assign hold_up_e   = engage ? 1'b0 : hold_up_q;
	assign hold_down_e = engage ? 1'b0 : hold_down_q;
	assign cool_e      = engage ? 1'b0 : cool_q;

	assign plan_age = now_ms - plan_time_q;
	assign cool_age = now_ms - cool_start_q;
	assign fresh    = plan_seen_q && (plan_age <= PLAN_TIMEOUT_MS);
	assign cooling  = cool_e && (cool_age < {{(TIME_W-COOLDOWN_W){1'b0}}, cfg.cooldown});

	// target limited by ceiling, error against set speed
	assign want    = (plan_speed_q < ceil_e) ? plan_speed_q : ceil_e;
	assign set_x   = {{2{set_e[SPEED_BITS-1]}}, set_e};
	assign ceil_x  = {{2{ceil_e[SPEED_BITS-1]}}, ceil_e};
	assign err     = {{2{want[SPEED_BITS-1]}}, want} - set_x;
	assign db_x    = {{(W-DEADBAND_W){1'b0}}, cfg.deadband};
	assign step_x  = {{(W-STEP_W){1'b0}}, cfg.step};
	assign big_err = (err >= db_x) || (err <= -db_x);
	assign err_pos = !err[W-1] && (err != '0);

	// next set speed for either tip direction
	assign up_n   = set_x + step_x;
	assign dn_n   = set_x - step_x;
	assign up_set = (up_n < ceil_x) ? up_n[SPEED_BITS-1:0] : ceil_e;
	assign dn_set = (dn_n > $signed({W{1'b0}})) ? dn_n[SPEED_BITS-1:0] : '0;

	// decision for one word
	always_comb begin
		engaged_d    = engaged_q;
		set_speed_d  = set_speed_q;
		ceiling_d    = ceiling_q;
		hold_up_d    = hold_up_q;
		hold_down_d  = hold_down_q;
		cool_d       = cool_q;
		cool_start_d = cool_start_q;
		cnt_press_d  = cnt_press_q;
		plan_seen_d  = plan_seen_q;
		plan_time_d  = plan_time_q;
		plan_speed_d = plan_speed_q;
		press        = '0;
		if (req_type == REQ_PLAN) begin
			plan_speed_d = target_speed;
			plan_seen_d  = 1'b1;
			plan_time_d  = now_ms;
		end else if (cfg.enable) begin
			set_speed_d = set_e;
			ceiling_d   = ceil_e;
			hold_up_d   = hold_up_e;
			hold_down_d = hold_down_e;
			cool_d      = cool_e;
			if (!cruise_on) begin
				engaged_d   = 1'b0;
				hold_up_d   = 1'b0;
				hold_down_d = 1'b0;
			end else begin
				engaged_d = 1'b1;
				if (gas_down || brake_down || !button_frame_valid) begin
					hold_up_d   = 1'b0;
					hold_down_d = 1'b0;
				end else if (hold_up_e || hold_down_e) begin
					press = '{send: 1'b1, up: hold_up_e, down: hold_down_e};
					if (button_counter != cnt_press_q) begin
						hold_up_d    = 1'b0;
						hold_down_d  = 1'b0;
						cool_d       = 1'b1;
						cool_start_d = now_ms;
					end
				end else begin
					if (cool_e && !cooling)
						cool_d = 1'b0;
					if (!cooling && fresh && big_err) begin
						cnt_press_d = button_counter;
						if (err_pos) begin
							hold_up_d   = 1'b1;
							set_speed_d = up_set;
							press       = '{send: 1'b1, up: 1'b1, down: 1'b0};
						end else begin
							hold_down_d = 1'b1;
							set_speed_d = dn_set;
							press       = '{send: 1'b1, up: 1'b0, down: 1'b1};
						end
					end
				end
			end
		end
	end

	// state update when a word is processed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			engaged_q    <= 1'b0;
			set_speed_q  <= '0;
			ceiling_q    <= '0;
			hold_up_q    <= 1'b0;
			hold_down_q  <= 1'b0;
			cool_q       <= 1'b0;
			cool_start_q <= '0;
			cnt_press_q  <= '0;
			plan_seen_q  <= 1'b0;
			plan_time_q  <= '0;
			plan_speed_q <= '0;
		end else if (fire) begin
			engaged_q    <= engaged_d;
			set_speed_q  <= set_speed_d;
			ceiling_q    <= ceiling_d;
			hold_up_q    <= hold_up_d;
			hold_down_q  <= hold_down_d;
			cool_q       <= cool_d;
			cool_start_q <= cool_start_d;
			cnt_press_q  <= cnt_press_d;
			plan_seen_q  <= plan_seen_d;
			plan_time_q  <= plan_time_d;
			plan_speed_q <= plan_speed_d;
		end
	end

endmodule

/* design/cruise_tip_button_controller.sv */
// cruise tip button controller: one accepted word per cycle unless a tick is stalled, press word per tick
// an accepted word waits in the input register until it is decided; a tick's result
//   is then written to the output register and offered on the output from there
// throughput: one word per cycle unless a tick is stalled, set by the single decision stage after the input register
// plan updates produce no output word; ticks produce exactly one
// reset (arst_n low): all controller state, configuration and valid flags clear to zero
module cruise_tip_button_controller #(
	parameter int COUNTER_BITS = 4,
	parameter int SPEED_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ctbc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic                                req_type,
	input  logic [ctbc_pkg::TIME_W-1:0]         now_ms,
	input  logic signed [SPEED_BITS-1:0]        target_speed,
	input  logic                                cruise_on,
	input  logic                                gas_down,
	input  logic                                brake_down,
	input  logic                                button_frame_valid,
	input  logic [COUNTER_BITS-1:0]             button_counter,
	input  logic signed [SPEED_BITS-1:0]        ego_speed,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic                                send_press,
	output logic                                press_up,
	output logic                                press_down
);
	import ctbc_pkg::*;

	cfg_t   cfg_q;
	press_t press;
	press_t press_q;
	logic   rsp_valid_q;

	// input register
	logic                          valid_s1;
	logic                          req_type_s1;
	logic [TIME_W-1:0]             now_ms_s1;
	logic signed [SPEED_BITS-1:0]  target_speed_s1;
	logic                          cruise_on_s1;
	logic                          gas_down_s1;
	logic                          brake_down_s1;
	logic                          frame_valid_s1;
	logic [COUNTER_BITS-1:0]       counter_s1;
	logic signed [SPEED_BITS-1:0]  ego_speed_s1;

	logic advance;

	// a plan word always leaves; a tick needs the output register free
	assign advance   = valid_s1 && (req_type_s1 == REQ_PLAN || !rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENABLE:   cfg_q.enable   <= cfg_data[0];
				REG_DEADBAND: cfg_q.deadband <= cfg_data[DEADBAND_W-1:0];
				REG_STEP:     cfg_q.step     <= cfg_data[STEP_W-1:0];
				REG_COOLDOWN: cfg_q.cooldown <= cfg_data[COOLDOWN_W-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_type_s1     <= req_type;
			now_ms_s1       <= now_ms;
			target_speed_s1 <= target_speed;
			cruise_on_s1    <= cruise_on;
			gas_down_s1     <= gas_down;
			brake_down_s1   <= brake_down;
			frame_valid_s1  <= button_frame_valid;
			counter_s1      <= button_counter;
			ego_speed_s1    <= ego_speed;
		end
	end

	ctbc_ctrl #(
		.COUNTER_BITS (COUNTER_BITS),
		.SPEED_BITS   (SPEED_BITS)
	) u_ctrl (
		.clk                (clk),
		.arst_n             (arst_n),
		.fire               (advance),
		.cfg                (cfg_q),
		.req_type           (req_type_s1),
		.now_ms             (now_ms_s1),
		.target_speed       (target_speed_s1),
		.cruise_on          (cruise_on_s1),
		.gas_down           (gas_down_s1),
		.brake_down         (brake_down_s1),
		.button_frame_valid (frame_valid_s1),
		.button_counter     (counter_s1),
		.ego_speed          (ego_speed_s1),
		.press              (press)
	);

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && req_type_s1 == REQ_TICK) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// output register word
	always_ff @(posedge clk) begin
		if (advance && req_type_s1 == REQ_TICK) begin
			press_q <= press;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign send_press = press_q.send;
	assign press_up   = press_q.up;
	assign press_down = press_q.down;

endmodule
